// File: hw/rtl/slm_pkg.sv
package slm_pkg;

    // Sample and level format: signed samples, unsigned levels, 1.0 = 65536
    localparam int unsigned SAMPLE_BITS  = 24;
    localparam int unsigned COEFF_BITS   = 16;
    localparam int unsigned TIMER_BITS   = 20;

    // Interpolation points between sample pairs; must stay a power of two
    localparam int unsigned INTERP_STEPS = 4;
    localparam int unsigned INTERP_LOG   = $clog2(INTERP_STEPS);

    // Entries of the request queue between front and back
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = TIMER_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RMS_COEFF    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_SAMPLES = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_COEFF  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_SAMPLES = 3'd4;

    localparam logic [COEFF_BITS-1:0] RMS_COEFF_RST    = 16'd65517;
    localparam logic                  HOLD_ENABLE_RST  = 1'b1;
    localparam logic [TIMER_BITS-1:0] HOLD_SAMPLES_RST = 20'd28800;
    localparam logic [COEFF_BITS-1:0] DECAY_COEFF_RST  = 16'd65528;
    localparam logic [TIMER_BITS-1:0] CLIP_SAMPLES_RST = 20'd8640;

    // Full scale: a true peak at or above this sets the clip timer
    localparam logic [SAMPLE_BITS-1:0] CLIP_LEVEL = SAMPLE_BITS'(65536);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } slm_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rms_level;
        logic [SAMPLE_BITS-1:0] true_peak;
        logic [SAMPLE_BITS-1:0] held_peak;
        logic                   clip_active;
    } slm_out_t;

    // One queued request: samples, magnitudes and half the energy
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]   left_sample;
        logic signed [SAMPLE_BITS-1:0]   right_sample;
        logic        [SAMPLE_BITS-1:0]   mag_left;
        logic        [SAMPLE_BITS-1:0]   mag_right;
        logic        [2*SAMPLE_BITS-2:0] energy;
    } slm_job_t;

    typedef struct packed {
        logic [COEFF_BITS-1:0] rms_coeff;
        logic                  peak_hold_enable;
        logic [TIMER_BITS-1:0] hold_samples;
        logic [COEFF_BITS-1:0] decay_coeff;
        logic [TIMER_BITS-1:0] clip_samples;
    } slm_cfg_t;

endpackage

// File: hw/rtl/slm_isqrt.sv
module slm_isqrt (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [2*slm_pkg::SAMPLE_BITS-1:0]      radicand,
    output logic                                   busy,
    output logic [slm_pkg::SAMPLE_BITS-1:0]        root
);
    import slm_pkg::*;

    localparam int unsigned RAD_W = 2 * SAMPLE_BITS;
    localparam int unsigned REM_W = SAMPLE_BITS + 2;
    localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [RAD_W-1:0]       rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [SAMPLE_BITS-1:0] root_reg;

    logic [REM_W-1:0]       rem_shift;
    logic [REM_W-1:0]       trial;
    logic                   take;

    // Restoring square root: one root bit per cycle
    assign rem_shift = {rem_reg[SAMPLE_BITS-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SAMPLE_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[SAMPLE_BITS-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/slm_front.sv
module slm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  slm_pkg::slm_in_t   in_data,
    output logic               push,
    output slm_pkg::slm_job_t  push_data,
    input  logic               full
);
    import slm_pkg::*;

    localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_l_reg;
    logic signed [SAMPLE_BITS-1:0] s1_r_reg;

    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_l_reg;
    logic signed [SAMPLE_BITS-1:0] s2_r_reg;
    logic        [SAMPLE_BITS-1:0] s2_ml_reg;
    logic        [SAMPLE_BITS-1:0] s2_mr_reg;
    logic        [SQ_W-1:0]        s2_sql_reg;
    logic        [SQ_W-1:0]        s2_sqr_reg;

    logic [SAMPLE_BITS-1:0] raw_l;
    logic [SAMPLE_BITS-1:0] raw_r;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [SQ_W-1:0]        sq_sum;
    logic                   s1_load;
    logic                   s2_load;

    assign raw_l = s1_l_reg;
    assign raw_r = s1_r_reg;
    // The most negative sample maps to 2^(SAMPLE_BITS-1), still in range
    assign mag_l = raw_l[SAMPLE_BITS-1] ? (~raw_l + SAMPLE_BITS'(1)) : raw_l;
    assign mag_r = raw_r[SAMPLE_BITS-1] ? (~raw_r + SAMPLE_BITS'(1)) : raw_r;

    assign push     = s2_valid_reg && !full;
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || push);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    assign sq_sum = s2_sql_reg + s2_sqr_reg;

    always_comb
    begin
        push_data.left_sample  = s2_l_reg;
        push_data.right_sample = s2_r_reg;
        push_data.mag_left     = s2_ml_reg;
        push_data.mag_right    = s2_mr_reg;
        push_data.energy       = sq_sum[SQ_W-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_l_reg <= in_data.left_sample;
            s1_r_reg <= in_data.right_sample;
        end
        if (s2_load)
        begin
            s2_l_reg   <= s1_l_reg;
            s2_r_reg   <= s1_r_reg;
            s2_ml_reg  <= mag_l;
            s2_mr_reg  <= mag_r;
            s2_sql_reg <= mag_l * mag_l;
            s2_sqr_reg <= mag_r * mag_r;
        end
    end

endmodule

// File: hw/rtl/slm_fifo.sv
module slm_fifo #(
    parameter int unsigned DEPTH = slm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  slm_pkg::slm_job_t  push_data,
    output logic               full,
    input  logic               pop,
    output slm_pkg::slm_job_t  pop_data,
    output logic               empty
);
    import slm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slm_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/slm_back.sv
module slm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  slm_pkg::slm_cfg_t  cfg,
    input  logic               empty,
    output logic               pop,
    input  slm_pkg::slm_job_t  job,
    output logic               out_valid,
    input  logic               out_stall,
    output slm_pkg::slm_out_t  out_data
);
    import slm_pkg::*;

    localparam int unsigned ACC_W    = SAMPLE_BITS + INTERP_LOG + 1;
    localparam int unsigned DIF_W    = SAMPLE_BITS + 1;
    localparam int unsigned ICNT_W   = $clog2(INTERP_STEPS + 1);
    localparam int unsigned PA_W     = COEFF_BITS + SAMPLE_BITS;
    localparam int unsigned PB_W     = COEFF_BITS + 1 + SAMPLE_BITS;
    localparam int unsigned SUM_W    = PB_W + 1;
    localparam int unsigned RAD_W    = 2 * SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [COEFF_BITS:0]  COEFF_ONE  = (COEFF_BITS + 1)'(1) << COEFF_BITS;
    localparam logic [SUM_W-1:0]     ROUND_HALF = SUM_W'(1) << (COEFF_BITS - 1);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Architectural state
    logic        [SAMPLE_BITS-1:0] rms_reg;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg;
    logic signed [SAMPLE_BITS-1:0] prev_r_reg;
    logic        [SAMPLE_BITS-1:0] hold_reg;
    logic        [TIMER_BITS-1:0]  htimer_reg;
    logic        [TIMER_BITS-1:0]  ctimer_reg;

    // Work registers of the request in flight
    logic signed [SAMPLE_BITS-1:0] cur_l_reg;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg;
    logic        [SAMPLE_BITS-1:0] peak_reg;
    logic signed [ACC_W-1:0]       acc_l_reg;
    logic signed [ACC_W-1:0]       acc_r_reg;
    logic signed [DIF_W-1:0]       dl_reg;
    logic signed [DIF_W-1:0]       dr_reg;
    logic        [ICNT_W-1:0]      icnt_reg;
    logic        [PA_W-1:0]        prod_a_reg;
    logic        [PB_W-1:0]        prod_b_reg;
    logic        [PA_W-1:0]        prod_d_reg;

    logic     out_valid_reg;
    slm_out_t out_data_reg;

    logic                          sq_busy;
    logic        [SAMPLE_BITS-1:0] sq_root;

    logic signed [DIF_W-1:0]       dl_new;
    logic signed [DIF_W-1:0]       dr_new;
    logic        [ACC_W-1:0]       raw_l;
    logic        [ACC_W-1:0]       raw_r;
    logic        [ACC_W-1:0]       mag_l;
    logic        [ACC_W-1:0]       mag_r;
    logic        [ACC_W:0]         rnd_l;
    logic        [ACC_W:0]         rnd_r;
    logic        [SAMPLE_BITS-1:0] cand_l;
    logic        [SAMPLE_BITS-1:0] cand_r;
    logic        [SAMPLE_BITS-1:0] peak_mid;
    logic        [SAMPLE_BITS-1:0] peak_step;
    logic        [SAMPLE_BITS-1:0] peak_first;

    logic        [SUM_W-1:0]       rms_sum;
    logic        [SAMPLE_BITS-1:0] rms_next;
    logic        [SAMPLE_BITS-1:0] decayed;
    logic        [SAMPLE_BITS-1:0] hold_next;
    logic        [TIMER_BITS-1:0]  htimer_inc;
    logic        [TIMER_BITS-1:0]  htimer_next;
    logic        [TIMER_BITS-1:0]  ctimer_next;
    logic                          commit;

    slm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .radicand (RAD_W'(job.energy)),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    assign pop    = (state_reg == ST_IDLE) && !empty;
    assign commit = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // Interpolation: acc walks prev*(N-i) + cur*i by adding (cur - prev)
    assign dl_new = DIF_W'(job.left_sample) - DIF_W'(prev_l_reg);
    assign dr_new = DIF_W'(job.right_sample) - DIF_W'(prev_r_reg);

    assign raw_l  = acc_l_reg;
    assign raw_r  = acc_r_reg;
    assign mag_l  = raw_l[ACC_W-1] ? (~raw_l + ACC_W'(1)) : raw_l;
    assign mag_r  = raw_r[ACC_W-1] ? (~raw_r + ACC_W'(1)) : raw_r;
    assign rnd_l  = {1'b0, mag_l} + (ACC_W + 1)'(INTERP_STEPS / 2);
    assign rnd_r  = {1'b0, mag_r} + (ACC_W + 1)'(INTERP_STEPS / 2);
    assign cand_l = SAMPLE_BITS'(rnd_l >> INTERP_LOG);
    assign cand_r = SAMPLE_BITS'(rnd_r >> INTERP_LOG);

    assign peak_mid   = (cand_l > peak_reg) ? cand_l : peak_reg;
    assign peak_step  = (cand_r > peak_mid) ? cand_r : peak_mid;
    assign peak_first = (job.mag_left > job.mag_right) ? job.mag_left : job.mag_right;

    // Level update at commit
    assign rms_sum  = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg) + ROUND_HALF;
    assign rms_next = rms_sum[COEFF_BITS +: SAMPLE_BITS];
    assign decayed  = prod_d_reg[COEFF_BITS +: SAMPLE_BITS];
    assign htimer_inc = (htimer_reg != TIMER_MAX) ? htimer_reg + TIMER_BITS'(1) : htimer_reg;

    always_comb
    begin
        hold_next   = peak_reg;
        htimer_next = '0;
        if (cfg.peak_hold_enable && (peak_reg < hold_reg))
        begin
            htimer_next = htimer_inc;
            hold_next   = hold_reg;
            if (htimer_inc > cfg.hold_samples)
            begin
                hold_next = (decayed < peak_reg) ? peak_reg : decayed;
            end
        end

        if (peak_reg >= CLIP_LEVEL)
        begin
            ctimer_next = cfg.clip_samples;
        end
        else if (ctimer_reg != '0)
        begin
            ctimer_next = ctimer_reg - TIMER_BITS'(1);
        end
        else
        begin
            ctimer_next = ctimer_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((icnt_reg == '0) && !sq_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            icnt_reg      <= '0;
            rms_reg       <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            hold_reg      <= '0;
            htimer_reg    <= '0;
            ctimer_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (pop)
            begin
                icnt_reg <= ICNT_W'(INTERP_STEPS - 1);
            end
            else if ((state_reg == ST_RUN) && (icnt_reg != '0))
            begin
                icnt_reg <= icnt_reg - ICNT_W'(1);
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                rms_reg       <= rms_next;
                prev_l_reg    <= cur_l_reg;
                prev_r_reg    <= cur_r_reg;
                hold_reg      <= hold_next;
                htimer_reg    <= htimer_next;
                ctimer_reg    <= ctimer_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_l_reg <= job.left_sample;
            cur_r_reg <= job.right_sample;
            peak_reg  <= peak_first;
            dl_reg    <= dl_new;
            dr_reg    <= dr_new;
            acc_l_reg <= (ACC_W'(prev_l_reg) <<< INTERP_LOG) + ACC_W'(dl_new);
            acc_r_reg <= (ACC_W'(prev_r_reg) <<< INTERP_LOG) + ACC_W'(dr_new);
        end
        else if ((state_reg == ST_RUN) && (icnt_reg != '0))
        begin
            peak_reg  <= peak_step;
            acc_l_reg <= acc_l_reg + ACC_W'(dl_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(dr_reg);
        end

        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= cfg.rms_coeff * rms_reg;
            prod_b_reg <= (COEFF_ONE - {1'b0, cfg.rms_coeff}) * sq_root;
            prod_d_reg <= hold_reg * cfg.decay_coeff;
        end

        if (commit)
        begin
            out_data_reg.rms_level   <= rms_next;
            out_data_reg.true_peak   <= peak_reg;
            out_data_reg.held_peak   <= hold_next;
            out_data_reg.clip_active <= (ctimer_next != '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/stereo_level_meter.sv
// Stereo level meter: smoothed RMS, interpolated true peak, peak hold with
// timed decay and a clip indicator for one stereo sample pair per request.
//
// Input channel: in_valid / in_stall / in_data carry one left/right pair.
// Output channel: out_valid / out_stall / out_data carry one result per
// input request, in order. Configuration: cfg_valid / cfg_ready write the
// register selected by cfg_index (0 rms_coeff, 1 peak_hold_enable,
// 2 hold_samples, 3 decay_coeff, 4 clip_samples); other indexes are ignored.
// cfg_ready is always high. Write configuration only while the meter is idle.
//
// The back end takes one request at a time; its pace is set by the square
// root unit, which resolves one root bit per cycle. A two-stage front end
// and a small request queue take in new pairs while the back end works, so
// short bursts are absorbed without stalling.
//
// Reset clears all levels, timers and the previous sample pair to zero and
// loads the register defaults. When out_stall is high the finished result
// holds in the output register; the back end waits, then the queue fills,
// then in_stall rises.
module stereo_level_meter #(
    parameter int unsigned QUEUE_DEPTH = slm_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  slm_pkg::slm_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output slm_pkg::slm_out_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [slm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import slm_pkg::*;

    // Configuration registers
    logic [COEFF_BITS-1:0] rms_coeff_reg;
    logic                  hold_enable_reg;
    logic [TIMER_BITS-1:0] hold_samples_reg;
    logic [COEFF_BITS-1:0] decay_coeff_reg;
    logic [TIMER_BITS-1:0] clip_samples_reg;

    slm_cfg_t cfg;
    logic     cfg_write;

    // Front to queue, queue to back
    logic     push;
    slm_job_t push_data;
    logic     full;
    logic     pop;
    slm_job_t pop_data;
    logic     empty;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode register writes; unused data bits drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rms_coeff_reg    <= RMS_COEFF_RST;
            hold_enable_reg  <= HOLD_ENABLE_RST;
            hold_samples_reg <= HOLD_SAMPLES_RST;
            decay_coeff_reg  <= DECAY_COEFF_RST;
            clip_samples_reg <= CLIP_SAMPLES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RMS_COEFF:    rms_coeff_reg    <= cfg_data[COEFF_BITS-1:0];
                REG_HOLD_ENABLE:  hold_enable_reg  <= cfg_data[0];
                REG_HOLD_SAMPLES: hold_samples_reg <= cfg_data[TIMER_BITS-1:0];
                REG_DECAY_COEFF:  decay_coeff_reg  <= cfg_data[COEFF_BITS-1:0];
                REG_CLIP_SAMPLES: clip_samples_reg <= cfg_data[TIMER_BITS-1:0];
                default:
                begin
                    rms_coeff_reg <= rms_coeff_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.rms_coeff        = rms_coeff_reg;
        cfg.peak_hold_enable = hold_enable_reg;
        cfg.hold_samples     = hold_samples_reg;
        cfg.decay_coeff      = decay_coeff_reg;
        cfg.clip_samples     = clip_samples_reg;
    end

    // Front end: take the pair, form magnitudes and energy
    slm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Request queue decoupling the two ends
    slm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back end: square root, interpolation, smoothing, hold and clip
    slm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .pop       (pop),
        .job       (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
